@@ rtl/rcio_pkg.sv @@
// ----------------------------------------------------------------------------
// rcio_pkg
// Shared types and decode constants for the I/O port decoder.
// ----------------------------------------------------------------------------
package rcio_pkg;

  localparam int SND_REGS  = 16;
  localparam int SND_AW    = 4;

  // Byte values on the data bus.
  localparam logic [7:0] IDLE_BYTE   = 8'hA0;
  localparam logic [7:0] ULA_HI_ONE  = 8'hA0;  // bits 7 and 5 always read as one
  localparam logic [7:0] ULA_HI_ISS  = 8'hE0;  // as above, with bit 6 set
  localparam logic [7:0] ULA_B6_CLR  = 8'hBF;
  localparam logic [7:0] ULA_B6_SRC  = 8'h18;  // last ULA write bits that drive bit 6

  // Address decode patterns.
  localparam logic [1:0] HI_SND_SEL  = 2'b11;
  localparam logic [1:0] HI_PRIMARY  = 2'b01;
  localparam logic [3:0] HI_SECOND   = 4'b0001;

  // Everything the first stage hands to the output register.
  typedef struct packed {
    logic [7:0] rd;          // read byte, unless the sound file supplies it
    logic       snd_rd;      // read byte comes from the sound register file
    logic       snd_hit;     // that entry has been written since reset
    logic [2:0] border;
    logic       speaker;
    logic       mic;
    logic [2:0] bank;
    logic [1:0] rom;
    logic       video;
    logic       lock;
    logic       mode;
  } stage_t;

endpackage

@@ rtl/retro_computer_io_port_decoder.sv @@
// ----------------------------------------------------------------------------
// retro_computer_io_port_decoder
// Partial I/O port decode: ULA, joystick, sound register file and paging.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   input   | in_valid / in_ready  | req_type, port_low/high, write_data, ...
//   output  | out_valid / out_ready| read_data, border_color, ram_bank, ...
//
// One item per cycle is sustained while the output is not stalled. Each result
// is registered in the first stage and then in the output register; the
// extra stage covers the registered read of the sound register RAM.
// Reset clears all latches and marks every sound register as unwritten, so
// it reads as zero until a data write reaches it. A stalled output holds its
// result; one further item can sit in the first stage behind it.
// ----------------------------------------------------------------------------
module retro_computer_io_port_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  port_low,
  input  logic [7:0]  port_high,
  input  logic [7:0]  write_data,
  input  logic [63:0] key_matrix,
  input  logic [7:0]  joystick,
  input  logic        tape_play,
  input  logic        tape_record,
  input  logic        tape_ear,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [2:0]  border_color,
  output logic        speaker_level,
  output logic        mic_level,
  output logic [2:0]  ram_bank,
  output logic [1:0]  rom_select,
  output logic        video_page,
  output logic        paging_locked,
  output logic        special_mode
);

  // Architectural latches.
  logic [7:0] last_ula_write, last_ula_write_next;
  logic [2:0] border_reg, border_reg_next;
  logic       speaker_reg, speaker_reg_next;
  logic       mic_reg, mic_reg_next;
  logic [rcio_pkg::SND_AW-1:0] sound_select, sound_select_next;
  logic [rcio_pkg::SND_REGS-1:0] snd_valid;
  logic       lock_flag, lock_flag_next;
  logic       rom_latch, rom_latch_next;
  logic       video_latch, video_latch_next;
  logic [2:0] bank_latch, bank_latch_next;
  logic       mode_bit, mode_bit_next;
  logic       rom_high_bit, rom_high_bit_next;

  // Pipeline.
  logic              s1_valid;
  rcio_pkg::stage_t  s1, s1_next;
  logic              accept, s1_move;
  logic              snd_we;
  logic [7:0]        ram_q;
  logic [7:0]        keys;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;
  assign snd_we   = accept && req_type && !port_low[1] && port_high[7] && !port_high[6];

  // AND of every keyboard row whose select bit is low.
  always_comb begin
    keys = 8'hFF;
    for (int k = 0; k < 8; k++) begin
      if (!port_high[k]) begin
        keys = keys & key_matrix[8*k +: 8];
      end
    end
  end

  always_comb begin
    last_ula_write_next = last_ula_write;
    border_reg_next     = border_reg;
    speaker_reg_next    = speaker_reg;
    mic_reg_next        = mic_reg;
    sound_select_next   = sound_select;
    lock_flag_next      = lock_flag;
    rom_latch_next      = rom_latch;
    video_latch_next    = video_latch;
    bank_latch_next     = bank_latch;
    mode_bit_next       = mode_bit;
    rom_high_bit_next   = rom_high_bit;
    s1_next             = '0;

    if (req_type) begin
      // Every device whose decode matches takes the write.
      if (!port_low[0]) begin
        border_reg_next     = write_data[2:0];
        speaker_reg_next    = tape_record ? write_data[3] : write_data[4];
        mic_reg_next        = write_data[3];
        last_ula_write_next = tape_play ? 8'h00 : write_data;
      end
      if (!port_low[1]) begin
        if (port_high[7:6] == rcio_pkg::HI_SND_SEL) begin
          sound_select_next = write_data[rcio_pkg::SND_AW-1:0];
        end
        if (port_high[7:6] == rcio_pkg::HI_PRIMARY && !lock_flag) begin
          lock_flag_next   = write_data[5];
          rom_latch_next   = write_data[4];
          video_latch_next = write_data[3];
          bank_latch_next  = write_data[2:0];
        end
        if (port_high[7:4] == rcio_pkg::HI_SECOND) begin
          mode_bit_next     = write_data[0];
          rom_high_bit_next = write_data[2];
        end
      end
    end else begin
      priority if (!port_low[0]) begin
        if (tape_play) begin
          s1_next.rd       = ((keys | rcio_pkg::ULA_HI_ONE) & rcio_pkg::ULA_B6_CLR)
                             | {1'b0, tape_ear, 6'b0};
          speaker_reg_next = tape_ear;
        end else if ((last_ula_write & rcio_pkg::ULA_B6_SRC) != 8'h00) begin
          s1_next.rd = (keys & rcio_pkg::ULA_B6_CLR) | rcio_pkg::ULA_HI_ISS;
        end else begin
          s1_next.rd = (keys & rcio_pkg::ULA_B6_CLR) | rcio_pkg::ULA_HI_ONE;
        end
      end else if (port_low[7:5] == 3'b000) begin
        s1_next.rd = joystick;
      end else if (port_high[7:6] == rcio_pkg::HI_SND_SEL && !port_low[1]) begin
        s1_next.snd_rd  = 1'b1;
        s1_next.snd_hit = snd_valid[sound_select];
      end else begin
        s1_next.rd = rcio_pkg::IDLE_BYTE;
      end
    end

    s1_next.border  = border_reg_next;
    s1_next.speaker = speaker_reg_next;
    s1_next.mic     = mic_reg_next;
    s1_next.bank    = bank_latch_next;
    s1_next.rom     = {rom_high_bit_next, rom_latch_next};
    s1_next.video   = video_latch_next;
    s1_next.lock    = lock_flag_next;
    s1_next.mode    = mode_bit_next;
  end

  // Reads are issued only on accept, so the read data holds while stage one
  // waits. A write item also issues a read, but its read data goes unused.
  rcio_ram #(
    .WIDTH (8),
    .DEPTH (rcio_pkg::SND_REGS)
  ) u_snd_ram (
    .clk   (clk),
    .we    (snd_we),
    .waddr (sound_select),
    .wdata (write_data),
    .re    (accept),
    .raddr (sound_select),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ula_write <= '0;
      border_reg     <= '0;
      speaker_reg    <= 1'b0;
      mic_reg        <= 1'b0;
      sound_select   <= '0;
      snd_valid      <= '0;
      lock_flag      <= 1'b0;
      rom_latch      <= 1'b0;
      video_latch    <= 1'b0;
      bank_latch     <= '0;
      mode_bit       <= 1'b0;
      rom_high_bit   <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        last_ula_write <= last_ula_write_next;
        border_reg     <= border_reg_next;
        speaker_reg    <= speaker_reg_next;
        mic_reg        <= mic_reg_next;
        sound_select   <= sound_select_next;
        lock_flag      <= lock_flag_next;
        rom_latch      <= rom_latch_next;
        video_latch    <= video_latch_next;
        bank_latch     <= bank_latch_next;
        mode_bit       <= mode_bit_next;
        rom_high_bit   <= rom_high_bit_next;
      end
      if (snd_we) begin
        snd_valid[sound_select] <= 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_move) begin
      if (s1.snd_rd) begin
        read_data <= s1.snd_hit ? ram_q : 8'h00;
      end else begin
        read_data <= s1.rd;
      end
      border_color  <= s1.border;
      speaker_level <= s1.speaker;
      mic_level     <= s1.mic;
      ram_bank      <= s1.bank;
      rom_select    <= s1.rom;
      video_page    <= s1.video;
      paging_locked <= s1.lock;
      special_mode  <= s1.mode;
    end
  end

endmodule

@@ rtl/rcio_ram.sv @@
// ----------------------------------------------------------------------------
// rcio_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rcio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rcio_checker.sv @@
// ----------------------------------------------------------------------------
// rcio_checker
// Port-level checks for the I/O port decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rcio_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       paging_locked
);

  // No result can be pending straight after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented straight after reset");

  // Only reset releases the paging lock.
  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && paging_locked |=> !out_valid || paging_locked)
    else $error("paging lock released without reset");

  // Unless an item was just accepted, stage one is occupied only behind a held result.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(in_valid && in_ready) && !$past(rst) |-> in_ready)
    else $error("input stalled while the pipeline is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("stalled result changed or vanished");

endmodule

bind retro_computer_io_port_decoder rcio_checker u_rcio_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .read_data     (read_data),
  .paging_locked (paging_locked)
);

@@ sim/retro_computer_io_port_decoder_test.sv @@
// ----------------------------------------------------------------------------
// retro_computer_io_port_decoder_test
// Self-checking bench for the I/O port decoder. A queue of port accesses,
// directed and random, is driven on the input channel. Every
// accepted item is run through a port-level model of the decoder, and each
// result is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module retro_computer_io_port_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_READ     = 1'b0;
  localparam logic REQ_WRITE    = 1'b1;
  localparam int   RANDOM_ITEMS = 1000;
  localparam int   TAIL_ITEMS   = 40;
  localparam int   MAX_WAIT     = 17;
  localparam int   STALL_LIMIT  = 4000;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   MAX_PRINTED  = 40;
  localparam int   HOLD_EVERY   = 500;

  typedef struct packed {
    logic        is_write;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  data;
    logic [63:0] keys;
    logic [7:0]  joy;
    logic        loading;
    logic        saving;
    logic        ear;
  } port_access_t;

  typedef struct packed {
    logic [7:0] rd;
    logic [2:0] border;
    logic       speaker;
    logic       mic;
    logic [2:0] bank;
    logic [1:0] rom;
    logic       video;
    logic       lock;
    logic       mode;
  } port_result_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        req_type     = 1'b0;
  logic [7:0]  port_low     = 8'h00;
  logic [7:0]  port_high    = 8'h00;
  logic [7:0]  write_data   = 8'h00;
  logic [63:0] key_matrix   = 64'h0;
  logic [7:0]  joystick     = 8'h00;
  logic        tape_play    = 1'b0;
  logic        tape_record  = 1'b0;
  logic        tape_ear     = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  read_data;
  logic [2:0]  border_color;
  logic        speaker_level;
  logic        mic_level;
  logic [2:0]  ram_bank;
  logic [1:0]  rom_select;
  logic        video_page;
  logic        paging_locked;
  logic        special_mode;

  retro_computer_io_port_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .port_low      (port_low),
    .port_high     (port_high),
    .write_data    (write_data),
    .key_matrix    (key_matrix),
    .joystick      (joystick),
    .tape_play     (tape_play),
    .tape_record   (tape_record),
    .tape_ear      (tape_ear),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .border_color  (border_color),
    .speaker_level (speaker_level),
    .mic_level     (mic_level),
    .ram_bank      (ram_bank),
    .rom_select    (rom_select),
    .video_page    (video_page),
    .paging_locked (paging_locked),
    .special_mode  (special_mode)
  );

  // Shadow copy of the decoder's latches.
  logic [7:0] ula_last;
  logic [2:0] border_q;
  logic       spk_q;
  logic       mic_q;
  logic [3:0] snd_sel;
  logic [7:0] snd_file [rcio_pkg::SND_REGS];
  logic       lock_q;
  logic       rom_lo_q;
  logic       video_q;
  logic [2:0] bank_q;
  logic       mode_q;
  logic       rom_hi_q;

  port_access_t access_q [$];
  port_result_t expected_q [$];

  int   queued_n     = 0;
  int   accepted_n   = 0;
  int   results_n    = 0;
  int   err_count    = 0;
  int   idle_cycles  = 0;
  int   send_wait    = 0;
  int   recv_wait    = 0;
  int   send_calm    = 0;
  int   recv_calm    = 0;
  int   hold_left    = 0;
  int   next_hold_at = 300;
  bit   lock_allowed = 1'b0;
  logic in_taken     = 1'b0;
  logic out_taken    = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic clear_latches();
    ula_last = 8'h00;
    border_q = 3'd0;
    spk_q    = 1'b0;
    mic_q    = 1'b0;
    snd_sel  = 4'd0;
    for (int i = 0; i < rcio_pkg::SND_REGS; i++) snd_file[i] = 8'h00;
    lock_q   = 1'b0;
    rom_lo_q = 1'b0;
    video_q  = 1'b0;
    bank_q   = 3'd0;
    mode_q   = 1'b0;
    rom_hi_q = 1'b0;
  endtask

  // Applies one port access to the shadow latches and returns the result.
  function automatic port_result_t decode_access(port_access_t a);
    port_result_t r;
    logic [7:0]   rows;
    int           k;
    rows = 8'hFF;
    r.rd = 8'h00;
    if (a.is_write == REQ_WRITE) begin
      if (!a.lo[0]) begin
        border_q = a.data[2:0];
        spk_q    = a.saving ? a.data[3] : a.data[4];
        mic_q    = a.data[3];
        ula_last = a.loading ? 8'h00 : a.data;
      end
      if (!a.lo[1]) begin
        if (a.hi[7:6] == rcio_pkg::HI_SND_SEL) begin
          snd_sel = a.data[3:0];
        end else if (a.hi[7]) begin
          snd_file[snd_sel] = a.data;
        end
        if (a.hi[7:6] == rcio_pkg::HI_PRIMARY && !lock_q) begin
          lock_q   = a.data[5];
          rom_lo_q = a.data[4];
          video_q  = a.data[3];
          bank_q   = a.data[2:0];
        end
        if (a.hi[7:4] == rcio_pkg::HI_SECOND) begin
          mode_q   = a.data[0];
          rom_hi_q = a.data[2];
        end
      end
    end else if (!a.lo[0]) begin
      for (k = 0; k < 8; k++) begin
        if (!a.hi[k]) rows &= a.keys[8*k +: 8];
      end
      if (a.loading) begin
        // While loading, bit 6 and the speaker both follow the tape ear level.
        r.rd  = ((rows | rcio_pkg::ULA_HI_ONE) & rcio_pkg::ULA_B6_CLR) | {1'b0, a.ear, 6'b0};
        spk_q = a.ear;
      end else begin
        r.rd = (rows & rcio_pkg::ULA_B6_CLR) |
               (((ula_last & rcio_pkg::ULA_B6_SRC) != 8'h00) ?
                rcio_pkg::ULA_HI_ISS : rcio_pkg::ULA_HI_ONE);
      end
    end else if (a.lo[7:5] == 3'b000) begin
      r.rd = a.joy;
    end else if (a.hi[7:6] == rcio_pkg::HI_SND_SEL && !a.lo[1]) begin
      r.rd = snd_file[snd_sel];
    end else begin
      r.rd = rcio_pkg::IDLE_BYTE;
    end
    r.border  = border_q;
    r.speaker = spk_q;
    r.mic     = mic_q;
    r.bank    = bank_q;
    r.rom     = {rom_hi_q, rom_lo_q};
    r.video   = video_q;
    r.lock    = lock_q;
    r.mode    = mode_q;
    return r;
  endfunction

  // Either side draws a random wait of up to MAX_WAIT per item, with runs of back-to-back items.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(15, 60);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_count < MAX_PRINTED) begin
      $display("%0t ns: result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, results_n, what, got, want);
    end
    err_count++;
  endtask

  // The paging lock can only be cleared by reset, so it is kept off until the
  // last stretch of the run.
  task automatic push_access(port_access_t a);
    if (!lock_allowed && a.is_write == REQ_WRITE && !a.lo[1] &&
        a.hi[7:6] == rcio_pkg::HI_PRIMARY) begin
      a.data[5] = 1'b0;
    end
    access_q.push_back(a);
    queued_n++;
  endtask

  task automatic queue_fixed(logic w, logic [7:0] lo, logic [7:0] hi, logic [7:0] data,
                             logic [63:0] keys, logic [7:0] joy,
                             logic loading, logic saving, logic ear);
    port_access_t a;
    a = {w, lo, hi, data, keys, joy, loading, saving, ear};
    push_access(a);
  endtask

  task automatic random_access();
    port_access_t a;
    port_access_t b;
    a.is_write = REQ_READ;
    a.lo       = 8'($urandom);
    a.hi       = 8'($urandom);
    a.data     = 8'($urandom);
    a.keys     = {$urandom, $urandom};
    a.joy      = 8'($urandom);
    a.loading  = ($urandom_range(0, 3) == 0);
    a.saving   = ($urandom_range(0, 3) == 0);
    a.ear      = 1'($urandom);
    // Mostly released keys, as on a real keyboard.
    if ($urandom_range(0, 2) == 0) begin
      a.keys = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
    end
    case ($urandom_range(0, 10))
      0, 1: begin
        a.lo[0] = 1'b0;
        case ($urandom_range(0, 3))
          0: a.hi = 8'hFF;
          1: a.hi = 8'h00;
          2: a.hi = ~(8'h01 << $urandom_range(0, 7));
          default: ;
        endcase
      end
      2: begin
        a.lo[7:5] = 3'b000;
        a.lo[0]   = 1'b1;
      end
      3: begin
        a.hi[7:6] = rcio_pkg::HI_SND_SEL;
        a.lo[1:0] = 2'b01;
        if (a.lo[7:5] == 3'b000) a.lo[7] = 1'b1;
      end
      4: begin
        a.is_write = REQ_WRITE;
        a.lo[0]    = 1'b0;
      end
      5: begin
        // Select a sound register, write it and read it back.
        b          = a;
        b.is_write = REQ_WRITE;
        b.hi[7:6]  = rcio_pkg::HI_SND_SEL;
        b.lo[1]    = 1'b0;
        push_access(b);
        b.data     = 8'($urandom);
        b.hi[7:6]  = 2'b10;
        b.lo       = 8'($urandom);
        b.lo[1]    = 1'b0;
        push_access(b);
        a.hi[7:6]  = rcio_pkg::HI_SND_SEL;
        a.lo[1:0]  = 2'b01;
        a.lo[7]    = 1'b1;
      end
      6: begin
        a.is_write = REQ_WRITE;
        a.hi[7:6]  = rcio_pkg::HI_PRIMARY;
        a.lo[1]    = 1'b0;
      end
      7: begin
        a.is_write = REQ_WRITE;
        a.hi[7:4]  = rcio_pkg::HI_SECOND;
        a.lo[1]    = 1'b0;
      end
      8: a.lo[0] = 1'b1;
      default: a.is_write = 1'($urandom);
    endcase
    push_access(a);
  endtask

  task automatic directed_accesses();
    queue_fixed(REQ_READ,  8'hFE, 8'h00, 8'h00, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'hFE, 8'hFF, 8'hFF, 64'h0123_4567_89AB_CDEF, 8'h00,
                1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'h00, 8'hFE, 8'h00, 64'hFFFF_FFFF_FFFF_FF1E, 8'h00,
                1'b1, 1'b0, 1'b1);
    queue_fixed(REQ_READ,  8'hFE, 8'hFD, 8'h00, 64'hFFFF_FFFF_FFFF_E0FF, 8'h00,
                1'b1, 1'b1, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFE, 8'hFF, 8'h17, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'hFE, 8'h7F, 8'h00, 64'h5AFF_FFFF_FFFF_FFFF, 8'h00,
                1'b0, 1'b0, 1'b0);
    // While saving, the speaker follows the mic bit.
    queue_fixed(REQ_WRITE, 8'hFE, 8'h00, 8'h08, 64'h0, 8'h00, 1'b0, 1'b1, 1'b0);
    queue_fixed(REQ_READ,  8'hFE, 8'hAA, 8'h00, '1, 8'h00, 1'b0, 1'b0, 1'b1);
    // A border write during loading leaves nothing behind for bit 6.
    queue_fixed(REQ_WRITE, 8'hFE, 8'h00, 8'hFF, 64'h0, 8'h00, 1'b1, 1'b0, 1'b1);
    queue_fixed(REQ_READ,  8'hFE, 8'h55, 8'hFF, '1, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'h1F, 8'hFF, 8'h00, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'h01, 8'h00, 8'h00, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFD, 8'hFF, 8'hFF, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFD, 8'hBF, 8'hA5, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'hFD, 8'hFF, 8'h00, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFD, 8'hC0, 8'h30, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    // Register 0 has never been written and reads as zero.
    queue_fixed(REQ_READ,  8'hFD, 8'hC0, 8'h00, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'hFF, 8'hFF, 8'h00, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_READ,  8'hFF, 8'h3F, 8'h00, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFD, 8'h7F, 8'h1F, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'h00, 8'h40, 8'hC0, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFD, 8'h1F, 8'h05, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'h00, 8'h10, 8'hFA, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  // Sender: presents the queued items, idling between them.
  always @(negedge clk) begin
    port_access_t nxt;
    if (!rst && (!in_valid || in_taken)) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        nxt = access_q.pop_front();
        req_type     <= nxt.is_write;
        port_low     <= nxt.lo;
        port_high    <= nxt.hi;
        write_data   <= nxt.data;
        key_matrix   <= nxt.keys;
        joystick     <= nxt.joy;
        tape_play    <= nxt.loading;
        tape_record  <= nxt.saving;
        tape_ear     <= nxt.ear;
        in_valid     <= 1'b1;
        send_wait = draw_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus now and then a long hold-off that lets the
  // decoder fill up and push back on its input.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) recv_wait = draw_wait(recv_calm);
      if (results_n >= next_hold_at) begin
        next_hold_at += HOLD_EVERY;
        hold_left = $urandom_range(150, 300);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted item and checks every accepted result.
  always @(posedge clk) begin
    port_access_t acc;
    port_result_t got;
    port_result_t want;
    in_taken  <= in_valid && in_ready && !rst;
    out_taken <= out_valid && out_ready && !rst;
    if (rst) begin
      clear_latches();
    end else begin
      if (out_valid && out_ready) begin
        got = {read_data, border_color, speaker_level, mic_level, ram_bank,
               rom_select, video_page, paging_locked, special_mode};
        results_n++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'(got), 64'(0));
        end else begin
          want = expected_q.pop_front();
          if (got.rd !== want.rd)
            report_mismatch("read_data", 64'(got.rd), 64'(want.rd));
          if (got.border !== want.border)
            report_mismatch("border_color", 64'(got.border), 64'(want.border));
          if (got.speaker !== want.speaker)
            report_mismatch("speaker_level", 64'(got.speaker), 64'(want.speaker));
          if (got.mic !== want.mic)
            report_mismatch("mic_level", 64'(got.mic), 64'(want.mic));
          if (got.bank !== want.bank)
            report_mismatch("ram_bank", 64'(got.bank), 64'(want.bank));
          if (got.rom !== want.rom)
            report_mismatch("rom_select", 64'(got.rom), 64'(want.rom));
          if (got.video !== want.video)
            report_mismatch("video_page", 64'(got.video), 64'(want.video));
          if (got.lock !== want.lock)
            report_mismatch("paging_locked", 64'(got.lock), 64'(want.lock));
          if (got.mode !== want.mode)
            report_mismatch("special_mode", 64'(got.mode), 64'(want.mode));
        end
      end
      if (in_valid && in_ready) begin
        acc = {req_type, port_low, port_high, write_data, key_matrix, joystick,
               tape_play, tape_record, tape_ear};
        expected_q.push_back(decode_access(acc));
        accepted_n++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    directed_accesses();
    repeat (RANDOM_ITEMS) random_access();
    // Final stretch: lock primary paging, check that it sticks while the
    // secondary register still answers.
    lock_allowed = 1'b1;
    queue_fixed(REQ_WRITE, 8'hFD, 8'h7F, 8'h3F, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFD, 8'h7F, 8'h00, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(REQ_WRITE, 8'hFD, 8'h1F, 8'h05, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0);
    repeat (TAIL_ITEMS) random_access();

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (accepted_n != queued_n || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rcio_pkg.sv
rtl/rcio_ram.sv
rtl/retro_computer_io_port_decoder.sv
rtl/rcio_checker.sv
sim/retro_computer_io_port_decoder_test.sv
